/* design/lsbx_pkg.sv */
// Shared types, codes and constants of the LSB steganography extractor.
// No dependencies; every other design file imports this package.
`default_nettype none

package lsbx_pkg;

    localparam int HDR_SKIP_W           = 10;
    localparam logic [HDR_SKIP_W-1:0] HDR_SKIP_RESET = 10'd54;
    localparam int LENGTH_FIELD_BYTES_DEF = 4;
    localparam int QUEUE_DEPTH          = 2;
    localparam logic [31:0] LEN_UNKNOWN = 32'hFFFF_FFFF;

    // Result kinds
    localparam logic [1:0] KIND_NAME    = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_TRUNC      = 2'd1;
    localparam logic [1:0] ST_RAN_TO_END = 2'd2;

    // One classified request from the front to the back
    typedef struct packed {
        logic       has_byte;
        logic [7:0] data;
        logic       eof;
    } t_event;

    typedef enum logic [4:0] {
        PH_PLEN    = 5'b00001,
        PH_NLEN    = 5'b00010,
        PH_NAME    = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_DONE    = 5'b10000
    } t_phase;

    // Drop a hidden byte into a little-endian length word; bytes past the fourth are lost.
    function automatic logic [31:0] put_len_byte(logic [31:0] word, logic [3:0] idx,
                                                 logic [7:0] v);
        logic [31:0] res;
        res = word;
        if (idx < 4'd4) begin
            unique case (idx[1:0])
                2'd0: res[7:0]   = v;
                2'd1: res[15:8]  = v;
                2'd2: res[23:16] = v;
                2'd3: res[31:24] = v;
            endcase
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* design/lsbx_front.sv */
// Front of the extractor: holds header_skip, skips the header and packs LSBs into bytes.
// Depends on lsbx_pkg; feeds classified requests into lsbx_queue.
`default_nettype none

module lsbx_front import lsbx_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [HDR_SKIP_W-1:0] i_cfg_wr_data,
    input  wire logic                  i_accept,
    input  wire logic [7:0]            i_cover_byte,
    input  wire logic                  i_end_of_file,
    output logic                       o_push,
    output t_event                     o_event
);

    logic [HDR_SKIP_W-1:0] r_hdr_skip;
    logic                  r_in_hdr, n_in_hdr;
    logic [HDR_SKIP_W-1:0] r_skip_cnt, n_skip_cnt;
    logic [2:0]            r_bit_cnt, n_bit_cnt;
    logic [7:0]            r_shift, n_shift;
    logic [7:0]            sh_next;

    assign sh_next = {r_shift[6:0], i_cover_byte[0]};

    always_comb begin
        n_in_hdr   = r_in_hdr;
        n_skip_cnt = r_skip_cnt;
        n_bit_cnt  = r_bit_cnt;
        n_shift    = r_shift;
        o_push     = 1'b0;
        o_event    = '{has_byte: 1'b0, data: sh_next, eof: i_end_of_file};
        if (i_accept) begin
            if (r_in_hdr && (r_skip_cnt < r_hdr_skip)) begin
                n_skip_cnt = r_skip_cnt + 1'b1;
                o_push     = i_end_of_file;
            end else begin
                n_in_hdr = 1'b0;
                if (r_bit_cnt == 3'd7) begin
                    n_bit_cnt        = 3'd0;
                    n_shift          = 8'd0;
                    o_event.has_byte = 1'b1;
                    o_push           = 1'b1;
                end else begin
                    n_bit_cnt = r_bit_cnt + 1'b1;
                    n_shift   = sh_next;
                    o_push    = i_end_of_file;
                end
            end
            // restart the file: partial group is dropped
            if (i_end_of_file) begin
                n_in_hdr   = 1'b1;
                n_skip_cnt = '0;
                n_bit_cnt  = 3'd0;
                n_shift    = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_skip <= HDR_SKIP_RESET;
            r_in_hdr   <= 1'b1;
            r_skip_cnt <= '0;
            r_bit_cnt  <= 3'd0;
            r_shift    <= 8'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_hdr_skip <= i_cfg_wr_data;
            end
            r_in_hdr   <= n_in_hdr;
            r_skip_cnt <= n_skip_cnt;
            r_bit_cnt  <= n_bit_cnt;
            r_shift    <= n_shift;
        end
    end

endmodule

`default_nettype wire

/* design/lsbx_queue.sv */
// Short request queue between the front and the back of the extractor.
// Depends on lsbx_pkg for the request type and depth.
`default_nettype none

module lsbx_queue import lsbx_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_event i_event,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_valid,
    output t_event      o_event
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_event             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_event = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* design/lsbx_back.sv */
// Back of the extractor: parses length fields, emits name and payload bytes, flags the end.
// Depends on lsbx_pkg; takes requests from lsbx_queue and drives the output register.
`default_nettype none

module lsbx_back import lsbx_pkg::*; #(
    parameter int LENGTH_FIELD_BYTES = LENGTH_FIELD_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_q_valid,
    input  wire t_event     i_event,
    output logic            o_pop,
    input  wire logic       i_stall,
    output logic            o_valid,
    output logic [7:0]      o_out_byte,
    output logic [1:0]      o_out_kind,
    output logic            o_is_last,
    output logic [1:0]      o_status
);

    localparam int IDX_W = (LENGTH_FIELD_BYTES > 1) ? $clog2(LENGTH_FIELD_BYTES) : 1;

    t_phase             r_phase, n_phase;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [31:0]        r_plen, n_plen;
    logic [31:0]        r_nlen, n_nlen;
    logic [31:0]        r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    logic [7:0]         r_out_byte, n_out_byte;
    logic [1:0]         r_out_kind, n_out_kind;
    logic               r_is_last, n_is_last;
    logic [1:0]         r_status, n_status;

    logic               emit;
    logic               ended;
    logic               idx_last;
    logic [3:0]         idx_ext;
    logic [31:0]        cnt_inc;
    logic [31:0]        nlen_new;
    logic [1:0]         eof_st;

    assign o_pop      = i_q_valid && (!r_out_valid || !i_stall);
    assign idx_last   = (r_idx == IDX_W'(LENGTH_FIELD_BYTES - 1));
    assign idx_ext    = 4'(r_idx);
    assign cnt_inc    = r_cnt + 32'd1;
    assign nlen_new   = put_len_byte(r_nlen, idx_ext, i_event.data);

    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_plen     = r_plen;
        n_nlen     = r_nlen;
        n_cnt      = r_cnt;
        n_out_byte = r_out_byte;
        n_out_kind = r_out_kind;
        n_is_last  = r_is_last;
        n_status   = r_status;
        emit       = 1'b0;
        ended      = 1'b0;
        eof_st     = ST_TRUNC;
        if (o_pop && (r_phase != PH_DONE)) begin
            if (i_event.has_byte) begin
                unique case (r_phase)
                    PH_PLEN: begin
                        n_plen = put_len_byte(r_plen, idx_ext, i_event.data);
                        n_idx  = idx_last ? '0 : r_idx + 1'b1;
                        if (idx_last) begin
                            n_phase = PH_NLEN;
                        end
                    end
                    PH_NLEN: begin
                        n_nlen = nlen_new;
                        n_idx  = idx_last ? '0 : r_idx + 1'b1;
                        if (idx_last) begin
                            n_cnt = 32'd0;
                            if (nlen_new[31]) begin
                                n_nlen = 32'd0;
                            end
                            if (!nlen_new[31] && (nlen_new != 32'd0)) begin
                                n_phase = PH_NAME;
                            end else if (r_plen == 32'd0) begin
                                emit       = 1'b1;
                                ended      = 1'b1;
                                n_out_byte = 8'd0;
                                n_out_kind = KIND_STATUS;
                                n_is_last  = 1'b1;
                                n_status   = ST_OK;
                                n_phase    = PH_DONE;
                            end else begin
                                n_phase = PH_PAYLOAD;
                            end
                        end
                    end
                    PH_NAME: begin
                        emit       = 1'b1;
                        n_out_byte = i_event.data;
                        n_out_kind = KIND_NAME;
                        n_is_last  = 1'b0;
                        n_status   = ST_OK;
                        n_cnt      = cnt_inc;
                        if (cnt_inc == r_nlen) begin
                            n_cnt   = 32'd0;
                            n_phase = PH_PAYLOAD;
                            if (r_plen == 32'd0) begin
                                n_is_last = 1'b1;
                                ended     = 1'b1;
                                n_phase   = PH_DONE;
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        emit       = 1'b1;
                        n_out_byte = i_event.data;
                        n_out_kind = KIND_PAYLOAD;
                        n_is_last  = 1'b0;
                        n_status   = ST_OK;
                        n_cnt      = cnt_inc;
                        if (!r_plen[31] && (cnt_inc == r_plen)) begin
                            n_is_last = 1'b1;
                            ended     = 1'b1;
                            n_phase   = PH_DONE;
                        end
                    end
                    PH_DONE: begin
                    end
                endcase
            end
            if (i_event.eof && !ended) begin
                if (n_phase == PH_PAYLOAD) begin
                    eof_st = (r_plen == LEN_UNKNOWN) ? ST_RAN_TO_END : ST_OK;
                end
                if (!emit) begin
                    n_out_byte = 8'd0;
                    n_out_kind = KIND_STATUS;
                end
                emit      = 1'b1;
                n_is_last = 1'b1;
                n_status  = eof_st;
            end
        end
        // restart per-file state after the last cover byte
        if (o_pop && i_event.eof) begin
            n_phase = PH_PLEN;
            n_idx   = '0;
            n_plen  = LEN_UNKNOWN;
            n_nlen  = 32'd0;
            n_cnt   = 32'd0;
        end
        n_out_valid = o_pop ? emit : (r_out_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_PLEN;
            r_idx       <= '0;
            r_plen      <= LEN_UNKNOWN;
            r_nlen      <= 32'd0;
            r_cnt       <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_plen      <= n_plen;
            r_nlen      <= n_nlen;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_kind <= n_out_kind;
        r_is_last  <= n_is_last;
        r_status   <= n_status;
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_out_kind = r_out_kind;
    assign o_is_last  = r_is_last;
    assign o_status   = r_status;

endmodule

`default_nettype wire

/* design/lsb_stego_bmp_extractor.sv */
// Top level of the LSB steganography extractor for bitmap cover streams.
// Depends on lsbx_pkg, lsbx_front, lsbx_queue and lsbx_back.
//
// Usage:
//   Input channel (i_valid / o_stall): one cover byte per request with an end-of-file
//   flag. The first header_skip bytes are ignored; after them each group of eight
//   LSBs gives one hidden byte, first LSB in bit 7.
//   Output channel (o_valid / i_stall): name bytes, payload bytes and status-only
//   results, with is_last and status on the result that ends a hidden message.
//   Configuration: i_cfg_wr_en writes header_skip from i_cfg_wr_data; write it only
//   while the block is idle.
// Timing:
//   One cover byte is accepted every cycle while the queue has room. A result passes
//   through the queue and then the output register: the front (skip counter and bit
//   packing) pushes the request into the queue, and the back (length and item
//   counters) moves it from the queue head into the output register. A two-entry
//   queue parts the two, so the back drains while the front fills and vice versa.
// Reset and stall:
//   Reset clears all file state and sets header_skip to 54. While the receiver
//   stalls the output register holds its result; the back stops, the queue fills,
//   and o_stall rises once it is full. Every end of file restarts the per-file state.
`default_nettype none

module lsb_stego_bmp_extractor import lsbx_pkg::*; #(
    parameter int LENGTH_FIELD_BYTES = LENGTH_FIELD_BYTES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [HDR_SKIP_W-1:0] i_cfg_wr_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [7:0]            i_cover_byte,
    input  wire logic                  i_end_of_file,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [7:0]                 o_out_byte,
    output logic [1:0]                 o_out_kind,
    output logic                       o_is_last,
    output logic [1:0]                 o_status
);

    logic   accept;
    logic   q_full;
    logic   q_push;
    t_event q_in;
    logic   q_valid;
    t_event q_head;
    logic   q_pop;

    // stall the sender only when the queue has no room
    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    lsbx_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_cover_byte  (i_cover_byte),
        .i_end_of_file (i_end_of_file),
        .o_push        (q_push),
        .o_event       (q_in)
    );

    lsbx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_event (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_event (q_head)
    );

    lsbx_back #(
        .LENGTH_FIELD_BYTES (LENGTH_FIELD_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_event    (q_head),
        .o_pop      (q_pop),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_out_byte (o_out_byte),
        .o_out_kind (o_out_kind),
        .o_is_last  (o_is_last),
        .o_status   (o_status)
    );

endmodule

`default_nettype wire
